@@ rtl/tiled_surface_address_map_macros.svh @@
// Assertion macros shared by the tiled surface address map RTL.
`ifndef TILED_SURFACE_ADDRESS_MAP_MACROS_SVH
`define TILED_SURFACE_ADDRESS_MAP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, skipping cycles in reset.
`define TSAM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset cycles included.
`define TSAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSAM_ASSERT(lbl, clk, rst, prop, msg)
`define TSAM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/tsam_pkg.sv @@
// Shared types, widths and tile geometry for the tiled surface address map.
package tsam_pkg;

  // Field widths
  localparam int X_W        = 18;
  localparam int Y_W        = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 36;
  localparam int PITCH_W    = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int PROD_W     = Y_W + PITCH_W;

  // Tile geometry
  localparam int XT_WIDTH   = 512;
  localparam int XT_HEIGHT  = 8;
  localparam int YT_WIDTH   = 128;
  localparam int YT_HEIGHT  = 32;
  localparam int YT_COLUMN  = 16;
  localparam int XT_W_LOG2  = $clog2(XT_WIDTH);
  localparam int XT_H_LOG2  = $clog2(XT_HEIGHT);
  localparam int YT_W_LOG2  = $clog2(YT_WIDTH);
  localparam int YT_H_LOG2  = $clog2(YT_HEIGHT);
  localparam int YT_C_LOG2  = $clog2(YT_COLUMN);
  localparam int XT_TILE_LOG2 = $clog2(XT_WIDTH * XT_HEIGHT);
  localparam int YT_TILE_LOG2 = $clog2(YT_WIDTH * YT_HEIGHT);
  localparam int OFF_W = (XT_TILE_LOG2 > YT_TILE_LOG2) ? XT_TILE_LOG2 : YT_TILE_LOG2;

  // Swizzle: bit 6 takes in bit 9 (both modes) and bit 10 (X mode only)
  localparam int SWZ_BIT   = 6;
  localparam int SWZ_SRC_A = 9;
  localparam int SWZ_SRC_B = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWIZZLE_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILED_PITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE = 3'd4;

  // Tile mode codes
  localparam logic TILE_X = 1'b0;
  localparam logic TILE_Y = 1'b1;

  typedef struct packed {
    logic               tile_mode;
    logic               swizzle_enable;
    logic [PITCH_W-1:0] tiled_pitch;
    logic [PITCH_W-1:0] linear_pitch;
    logic               swap_red_blue;
  } tsam_cfg_t;

endpackage

@@ rtl/tiled_surface_address_map.sv @@
// Top level of the tiled surface address map: input and result registers.
// Usage:
//   Input channel (in_valid/in_ready) carries one word with its byte column
//   x_byte and row y_row. Output channel (out_valid/out_ready) returns the
//   word's tiled and linear byte addresses and the word, optionally with
//   bytes 0 and 2 exchanged.
//   A word accepted passes through the input register and then the result
//   register before it can be taken at the output.
//   Throughput: one word per cycle while out_ready stays high; the two
//   multiplies and the add chains sit between the input and result registers.
//   Configuration: cfg_we/cfg_index/cfg_data write a register at the edge;
//   write only while no word is in flight.
//   Reset: both stages empty, configuration registers cleared to X tiling,
//   swizzle off, zero pitches, no byte swap.
//   Stall: while out_ready is low the result holds; the input stage still
//   takes one more word, after which in_ready drops until out_ready returns.
`include "tiled_surface_address_map_macros.svh"
module tiled_surface_address_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsam_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tsam_pkg::X_W-1:0]        x_byte,
  input  logic [tsam_pkg::Y_W-1:0]        y_row,
  input  logic [tsam_pkg::DATA_W-1:0]     data_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tsam_pkg::ADDR_W-1:0]     tiled_addr,
  output logic [tsam_pkg::ADDR_W-1:0]     linear_addr,
  output logic [tsam_pkg::DATA_W-1:0]     data_out
);
  import tsam_pkg::*;

  tsam_cfg_t         cfg;
  logic              s1_valid;
  logic [X_W-1:0]    s1_x;
  logic [Y_W-1:0]    s1_y;
  logic [DATA_W-1:0] s1_data;
  logic              s1_adv;
  logic              s2_free;
  logic [ADDR_W-1:0] tiled_next, linear_next;
  logic [DATA_W-1:0] data_next;

  tsam_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage handshake: result register frees when empty or taken
  assign s2_free  = !out_valid || out_ready;
  assign s1_adv   = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x    <= x_byte;
      s1_y    <= y_row;
      s1_data <= data_word;
    end
  end

  tsam_addr_calc u_calc (
    .cfg         (cfg),
    .x_byte      (s1_x),
    .y_row       (s1_y),
    .data_word   (s1_data),
    .tiled_addr  (tiled_next),
    .linear_addr (linear_next),
    .data_out    (data_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tiled_addr  <= tiled_next;
      linear_addr <= linear_next;
      data_out    <= data_next;
    end
  end

  `TSAM_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!out_valid && !s1_valid), "stages not empty after reset")
  `TSAM_ASSERT(a_no_overrun, clk, rst, (in_valid && in_ready && s1_valid) |-> s1_adv, "input word overwrote a held word")
  `TSAM_ASSERT(a_stall_blocks, clk, rst, (out_valid && !out_ready) |-> !s1_adv, "input stage advanced into a stalled result")
  `TSAM_ASSERT(a_result_kept, clk, rst, (out_valid && !out_ready) |=> out_valid, "stalled result lost")
  `TSAM_ASSERT(a_advance_fills, clk, rst, s1_adv |=> out_valid, "advanced word did not reach the result register")

endmodule

@@ rtl/tsam_cfg_regs.sv @@
// Configuration register file of the tiled surface address map.
module tsam_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tsam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsam_pkg::CFG_DATA_W-1:0] cfg_data,
  output tsam_pkg::tsam_cfg_t            cfg
);
  import tsam_pkg::*;

  // Hold registers; write the addressed one, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_MODE:     cfg.tile_mode      <= cfg_data[0];
        REG_SWIZZLE_EN:    cfg.swizzle_enable <= cfg_data[0];
        REG_TILED_PITCH:   cfg.tiled_pitch    <= cfg_data[PITCH_W-1:0];
        REG_LINEAR_PITCH:  cfg.linear_pitch   <= cfg_data[PITCH_W-1:0];
        REG_SWAP_RED_BLUE: cfg.swap_red_blue  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tsam_addr_calc.sv @@
// Combinational tiled and linear address calculation plus byte swap.
module tsam_addr_calc (
  input  tsam_pkg::tsam_cfg_t          cfg,
  input  logic [tsam_pkg::X_W-1:0]     x_byte,
  input  logic [tsam_pkg::Y_W-1:0]     y_row,
  input  logic [tsam_pkg::DATA_W-1:0]  data_word,
  output logic [tsam_pkg::ADDR_W-1:0]  tiled_addr,
  output logic [tsam_pkg::ADDR_W-1:0]  linear_addr,
  output logic [tsam_pkg::DATA_W-1:0]  data_out
);
  import tsam_pkg::*;

  logic [ADDR_W-1:0] col_base_x, col_base_y, col_base;
  logic [Y_W-1:0]    row_org;
  logic [OFF_W-1:0]  off_x, off_y, off;
  logic [PROD_W-1:0] row_prod, lin_prod;

  // Tile column base: column tile index times tile size
  assign col_base_x = ADDR_W'(x_byte[X_W-1:XT_W_LOG2]) << XT_TILE_LOG2;
  assign col_base_y = ADDR_W'(x_byte[X_W-1:YT_W_LOG2]) << YT_TILE_LOG2;

  // X mode offset: rows of the tile stacked, swizzle from bits 9 and 10
  always_comb begin
    off_x = OFF_W'(x_byte[XT_W_LOG2-1:0])
          | (OFF_W'(y_row[XT_H_LOG2-1:0]) << XT_W_LOG2);
    if (cfg.swizzle_enable) begin
      off_x[SWZ_BIT] = off_x[SWZ_BIT] ^ off_x[SWZ_SRC_A] ^ off_x[SWZ_SRC_B];
    end
  end

  // Y mode offset: 16-byte columns each a full tile tall, swizzle from bit 9
  always_comb begin
    off_y = OFF_W'(x_byte[YT_C_LOG2-1:0])
          | (OFF_W'(y_row[YT_H_LOG2-1:0]) << YT_C_LOG2)
          | (OFF_W'(x_byte[YT_W_LOG2-1:YT_C_LOG2]) << (YT_C_LOG2 + YT_H_LOG2));
    if (cfg.swizzle_enable) begin
      off_y[SWZ_BIT] = off_y[SWZ_BIT] ^ off_y[SWZ_SRC_A];
    end
  end

  // Select mode; row origin is the first row of the tile
  always_comb begin
    case (cfg.tile_mode)
      TILE_X: begin
        col_base = col_base_x;
        off      = off_x;
        row_org  = y_row & ~Y_W'(XT_HEIGHT - 1);
      end
      TILE_Y: begin
        col_base = col_base_y;
        off      = off_y;
        row_org  = y_row & ~Y_W'(YT_HEIGHT - 1);
      end
      default: begin
        col_base = col_base_x;
        off      = off_x;
        row_org  = y_row & ~Y_W'(XT_HEIGHT - 1);
      end
    endcase
  end

  // One multiply and one add chain per address
  assign row_prod = PROD_W'(row_org) * PROD_W'(cfg.tiled_pitch);
  assign lin_prod = PROD_W'(y_row) * PROD_W'(cfg.linear_pitch);

  assign tiled_addr  = col_base + ADDR_W'(row_prod) + ADDR_W'(off);
  assign linear_addr = ADDR_W'(x_byte) + ADDR_W'(lin_prod);

  // Exchange bytes 0 and 2 when asked
  assign data_out = cfg.swap_red_blue
                  ? {data_word[31:24], data_word[7:0], data_word[15:8], data_word[23:16]}
                  : data_word;

endmodule
